FILE: hw/rtl/fixed_block_free_stack_allocator_assert.svh
// assertion macros for the block pool allocator checker
`ifndef FIXED_BLOCK_FREE_STACK_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_STACK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FBFS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBFS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fbfs_pkg.sv
// shared types and constants for the block pool allocator
package fbfs_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int COUNT_W    = IDX_W + 1;
    localparam int BYTES_W    = 17;
    localparam int ADDR_W     = 32;
    localparam int PROD_W     = IDX_W + BYTES_W;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = $clog2(ADDR_W);

    typedef enum logic [2:0] {
        ST_ALLOCATED  = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_FREED      = 3'd2,
        ST_NULL       = 3'd3,
        ST_OUTSIDE    = 3'd4,
        ST_MISALIGNED = 3'd5,
        ST_FULL       = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_BASE   = 2'd0,
        REG_BLOCK_BYTES = 2'd1,
        REG_BLOCK_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_MUL,
        S_ADD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] wdata;
    } stk_req_t;

    typedef struct packed {
        logic               start;
        logic [ADDR_W-1:0]  dividend;
        logic [BYTES_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [ADDR_W-1:0]  quotient;
        logic [BYTES_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: hw/rtl/fixed_block_free_stack_allocator.sv
// allocate: stack read, multiply, add, then the output register
// free of a nonzero address: waits on the 32-step serial divider, then the output
// register; null free and empty allocate go straight to the output register
// one request at a time: the next is taken the cycle after the result is registered;
// a stalled output holds the result, and with it the next request, back
// reset: state and config registers to defaults, stack written flags cleared so entry i reads as i
module fixed_block_free_stack_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbfs_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [fbfs_pkg::ADDR_W-1:0]       s_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [fbfs_pkg::ADDR_W-1:0]       m_block_address,
    output logic [fbfs_pkg::COUNT_W-1:0]      m_free_count
);

    fbfs_pkg::state_t             state_reg, state_next;
    logic [fbfs_pkg::ADDR_W-1:0]  pool_base_reg, pool_base_next;
    logic [fbfs_pkg::BYTES_W-1:0] block_bytes_reg, block_bytes_next;
    logic [fbfs_pkg::COUNT_W-1:0] block_count_reg, block_count_next;
    logic [fbfs_pkg::COUNT_W-1:0] free_top_reg, free_top_next;
    logic [fbfs_pkg::PROD_W-1:0]  prod_reg, prod_next;
    fbfs_pkg::status_t            res_status_reg, res_status_next;
    logic [fbfs_pkg::ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic                         m_valid_reg, m_valid_next;
    fbfs_pkg::status_t            m_status_reg, m_status_next;
    logic [fbfs_pkg::ADDR_W-1:0]  m_addr_reg, m_addr_next;
    logic [fbfs_pkg::COUNT_W-1:0] m_count_reg, m_count_next;

    logic [fbfs_pkg::COUNT_W-1:0] eff_count;
    logic [fbfs_pkg::COUNT_W-1:0] new_count;
    logic [fbfs_pkg::BYTES_W-1:0] eff_bytes;

    fbfs_pkg::stk_req_t           stk_req;
    logic [fbfs_pkg::IDX_W-1:0]   stk_rd_data;
    fbfs_pkg::div_req_t           div_req;
    fbfs_pkg::div_rsp_t           div_rsp;

    fbfs_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (stk_req),
        .rd_data (stk_rd_data)
    );

    fbfs_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        eff_count = (block_count_reg > fbfs_pkg::COUNT_W'(fbfs_pkg::MAX_BLOCKS))
                  ? fbfs_pkg::COUNT_W'(fbfs_pkg::MAX_BLOCKS) : block_count_reg;
        new_count = (cfg_data[fbfs_pkg::COUNT_W-1:0] > fbfs_pkg::COUNT_W'(fbfs_pkg::MAX_BLOCKS))
                  ? fbfs_pkg::COUNT_W'(fbfs_pkg::MAX_BLOCKS) : cfg_data[fbfs_pkg::COUNT_W-1:0];
        eff_bytes = (block_bytes_reg == '0) ? fbfs_pkg::BYTES_W'(1) : block_bytes_reg;
    end

    always_comb begin
        state_next       = state_reg;
        pool_base_next   = pool_base_reg;
        block_bytes_next = block_bytes_reg;
        block_count_next = block_count_reg;
        free_top_next    = free_top_reg;
        prod_next        = prod_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_addr_next      = m_addr_reg;
        m_count_next     = m_count_reg;
        s_ready          = 1'b0;
        stk_req          = '0;
        div_req.start    = 1'b0;
        div_req.dividend = s_address - pool_base_reg;
        div_req.divisor  = eff_bytes;

        unique case (state_reg)
            fbfs_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_addr_next = '0;
                    if (!s_kind) begin
                        if (free_top_reg == '0) begin
                            res_status_next = fbfs_pkg::ST_EMPTY;
                            state_next      = fbfs_pkg::S_OUT;
                        end else begin
                            free_top_next = free_top_reg - 1'b1;
                            state_next    = fbfs_pkg::S_RD;
                        end
                    end else if (s_address == '0) begin
                        res_status_next = fbfs_pkg::ST_NULL;
                        state_next      = fbfs_pkg::S_OUT;
                    end else begin
                        div_req.start = 1'b1;
                        state_next    = fbfs_pkg::S_DIV;
                    end
                end
            end
            fbfs_pkg::S_RD: begin
                stk_req.rd_en = 1'b1;
                stk_req.addr  = free_top_reg[fbfs_pkg::IDX_W-1:0];
                state_next    = fbfs_pkg::S_MUL;
            end
            fbfs_pkg::S_MUL: begin
                prod_next  = fbfs_pkg::PROD_W'(stk_rd_data) * fbfs_pkg::PROD_W'(eff_bytes);
                state_next = fbfs_pkg::S_ADD;
            end
            fbfs_pkg::S_ADD: begin
                res_addr_next   = pool_base_reg + fbfs_pkg::ADDR_W'(prod_reg);
                res_status_next = fbfs_pkg::ST_ALLOCATED;
                state_next      = fbfs_pkg::S_OUT;
            end
            fbfs_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    // quotient at or past the count means past the end of the pool
                    if (div_rsp.quotient >= fbfs_pkg::ADDR_W'(eff_count)) begin
                        res_status_next = fbfs_pkg::ST_OUTSIDE;
                    end else if (div_rsp.remainder != '0) begin
                        res_status_next = fbfs_pkg::ST_MISALIGNED;
                    end else if (free_top_reg >= eff_count) begin
                        res_status_next = fbfs_pkg::ST_FULL;
                    end else begin
                        stk_req.wr_en   = 1'b1;
                        stk_req.addr    = free_top_reg[fbfs_pkg::IDX_W-1:0];
                        stk_req.wdata   = div_rsp.quotient[fbfs_pkg::IDX_W-1:0];
                        free_top_next   = free_top_reg + 1'b1;
                        res_status_next = fbfs_pkg::ST_FREED;
                    end
                    state_next = fbfs_pkg::S_OUT;
                end
            end
            fbfs_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    m_count_next  = free_top_reg;
                    state_next    = fbfs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fbfs_pkg::S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                fbfs_pkg::REG_POOL_BASE: begin
                    pool_base_next = cfg_data;
                end
                fbfs_pkg::REG_BLOCK_BYTES: begin
                    block_bytes_next = cfg_data[fbfs_pkg::BYTES_W-1:0];
                end
                fbfs_pkg::REG_BLOCK_COUNT: begin
                    block_count_next = cfg_data[fbfs_pkg::COUNT_W-1:0];
                    free_top_next    = new_count;
                    stk_req.clear    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_count_reg    <= m_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fbfs_pkg::S_IDLE;
            pool_base_reg   <= '0;
            block_bytes_reg <= fbfs_pkg::BYTES_W'(64);
            block_count_reg <= fbfs_pkg::COUNT_W'(fbfs_pkg::MAX_BLOCKS);
            free_top_reg    <= fbfs_pkg::COUNT_W'(fbfs_pkg::MAX_BLOCKS);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pool_base_reg   <= pool_base_next;
            block_bytes_reg <= block_bytes_next;
            block_count_reg <= block_count_next;
            free_top_reg    <= free_top_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_block_address = m_addr_reg;
    assign m_free_count    = m_count_reg;

endmodule

FILE: hw/rtl/fbfs_stack.sv
// free stack storage with per-entry written flags, unwritten entries read as their index
module fbfs_stack (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fbfs_pkg::stk_req_t            req,
    output logic [fbfs_pkg::IDX_W-1:0]    rd_data
);

    logic [fbfs_pkg::IDX_W-1:0]      mem_reg [fbfs_pkg::MAX_BLOCKS];
    logic [fbfs_pkg::MAX_BLOCKS-1:0] written_reg;
    logic [fbfs_pkg::IDX_W-1:0]      rd_mem_reg;
    logic [fbfs_pkg::IDX_W-1:0]      rd_addr_reg;
    logic                            rd_written_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_mem_reg     <= mem_reg[req.addr];
            rd_addr_reg    <= req.addr;
            rd_written_reg <= written_reg[req.addr];
        end
    end

    // refill just forgets every write
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            written_reg <= '0;
        end else if (req.wr_en) begin
            written_reg[req.addr] <= 1'b1;
        end
    end

    assign rd_data = rd_written_reg ? rd_mem_reg : rd_addr_reg;

endmodule

FILE: hw/rtl/fbfs_divider.sv
// serial restoring divider, one quotient bit per cycle
module fbfs_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  fbfs_pkg::div_req_t req,
    output fbfs_pkg::div_rsp_t rsp
);

    logic [fbfs_pkg::BYTES_W-1:0] rem_reg, rem_next;
    logic [fbfs_pkg::ADDR_W-1:0]  quo_reg, quo_next;
    logic [fbfs_pkg::BYTES_W-1:0] dvs_reg, dvs_next;
    logic [fbfs_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [fbfs_pkg::BYTES_W:0]   trial;
    logic [fbfs_pkg::BYTES_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[fbfs_pkg::ADDR_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the trial fits one extra bit
            if (!diff[fbfs_pkg::BYTES_W]) begin
                rem_next = diff[fbfs_pkg::BYTES_W-1:0];
                quo_next = {quo_reg[fbfs_pkg::ADDR_W-2:0], 1'b1};
            end else begin
                rem_next = trial[fbfs_pkg::BYTES_W-1:0];
                quo_next = {quo_reg[fbfs_pkg::ADDR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fbfs_pkg::STEP_W'(fbfs_pkg::ADDR_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hw/rtl/fbfs_checker.sv
// port-level checks on the block pool allocator, bound to the top level
`include "fixed_block_free_stack_allocator_assert.svh"

module fbfs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [2:0]                   m_status,
    input logic [fbfs_pkg::ADDR_W-1:0]  m_block_address,
    input logic [fbfs_pkg::COUNT_W-1:0] m_free_count
);

    // only an allocation carries an address
    `FBFS_ASSERT_IMP(a_addr_zero, aclk, aresetn, m_valid && (m_status != fbfs_pkg::ST_ALLOCATED), m_block_address == '0, "address on a word that is not an allocation")

    // empty answer only when nothing is free
    `FBFS_ASSERT_IMP(a_empty_count, aclk, aresetn, m_valid && (m_status == fbfs_pkg::ST_EMPTY), m_free_count == '0, "pool empty with free blocks left")

    // a pop leaves the count at least one below the full pool, a push leaves at least one
    `FBFS_ASSERT_IMP(a_alloc_count, aclk, aresetn, m_valid && (m_status == fbfs_pkg::ST_ALLOCATED), m_free_count < fbfs_pkg::COUNT_W'(fbfs_pkg::MAX_BLOCKS), "allocation with a full free count")
    `FBFS_ASSERT_IMP(a_freed_count, aclk, aresetn, m_valid && (m_status == fbfs_pkg::ST_FREED), m_free_count != '0, "free left the count at zero")

    `FBFS_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_block_address), "stalled word changed")

endmodule

bind fixed_block_free_stack_allocator fbfs_checker u_fbfs_checker (.*);

FILE: tb/fixed_block_free_stack_allocator_test.sv
// self-checking testbench for the fixed block free stack allocator
`timescale 1ns / 1ps

import fbfs_pkg::*;

typedef enum bit {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
} req_kind_t;

typedef struct packed {
    status_t     status;
    logic [31:0] block_address;
    logic [8:0]  free_count;
} pool_word_t;

class block_pool_scoreboard;
    logic [31:0] base;
    logic [16:0] bytes;
    logic [8:0]  count;
    logic [7:0]  stack [MAX_BLOCKS];
    logic [8:0]  top;
    logic [31:0] live [$];
    pool_word_t  expected_words [$];
    int          errors;

    function new();
        base   = 32'd0;
        bytes  = 17'd64;
        count  = 9'd256;
        errors = 0;
        refill();
    endfunction

    function logic [8:0] eff_count();
        return (count > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : count;
    endfunction

    function logic [16:0] eff_bytes();
        return (bytes == 17'd0) ? 17'd1 : bytes;
    endfunction

    function void refill();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            stack[i] = 8'(i);
        end
        top = eff_count();
        live.delete();
    endfunction

    function void set_register(cfg_reg_t idx, logic [31:0] value);
        case (idx)
            REG_POOL_BASE: begin
                base = value;
            end
            REG_BLOCK_BYTES: begin
                bytes = value[16:0];
            end
            REG_BLOCK_COUNT: begin
                count = value[8:0];
                refill();
            end
            default: begin
            end
        endcase
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // works out the response word for one accepted request
    function void predict_request(req_kind_t kind, logic [31:0] address);
        logic [8:0]  cnt;
        logic [16:0] eb;
        logic [31:0] offset;
        logic [63:0] span;
        logic [7:0]  idx;
        pool_word_t  w;
        cnt = eff_count();
        eb  = eff_bytes();
        if (top > cnt) top = cnt;
        w.block_address = 32'd0;
        if (kind == REQ_ALLOC) begin
            if (top == 9'd0) begin
                w.status = ST_EMPTY;
            end else begin
                top = top - 9'd1;
                idx = stack[top[7:0]];
                w.block_address = base + 32'(idx) * 32'(eb);
                w.status = ST_ALLOCATED;
                live.push_back(w.block_address);
            end
        end else if (address == 32'd0) begin
            w.status = ST_NULL;
        end else begin
            offset = address - base;
            span   = 64'(eb) * 64'(cnt);
            if (64'(offset) >= span) begin
                w.status = ST_OUTSIDE;
            end else if (offset % 32'(eb) != 32'd0) begin
                w.status = ST_MISALIGNED;
            end else if (top >= cnt) begin
                w.status = ST_FULL;
            end else begin
                stack[top[7:0]] = 8'(offset / 32'(eb));
                top = top + 9'd1;
                w.status = ST_FREED;
            end
        end
        w.free_count = top;
        expected_words.push_back(w);
    endfunction

    function void check_word(logic [2:0] status, logic [31:0] block_address,
                             logic [8:0] free_count);
        pool_word_t w;
        if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: word with nothing expected: status %0d address %h count %0d",
                     $time, status, block_address, free_count);
            return;
        end
        w = expected_words.pop_front();
        if (status !== w.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, w.status, status);
        end
        if (block_address !== w.block_address) begin
            errors++;
            $display("%0t: block_address expected %h actual %h",
                     $time, w.block_address, block_address);
        end
        if (free_count !== w.free_count) begin
            errors++;
            $display("%0t: free_count expected %0d actual %0d",
                     $time, w.free_count, free_count);
        end
    endfunction
endclass

module fixed_block_free_stack_allocator_test;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    cfg_reg_t             cfg_index = REG_POOL_BASE;
    logic [ADDR_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_kind = 1'b0;
    logic [ADDR_W-1:0]    s_address = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [ADDR_W-1:0]    m_block_address;
    logic [COUNT_W-1:0]   m_free_count;

    block_pool_scoreboard sb = new();

    int send_gap_max = 18;
    int recv_gap_max = 18;
    int hold_off     = 0;

    fixed_block_free_stack_allocator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_address       (s_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_block_address (m_block_address),
        .m_free_count    (m_free_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_status, m_block_address, m_free_count);
        end
    end

    task automatic run_request(req_kind_t kind, logic [31:0] address);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_address <= address;
        do @(posedge aclk); while (!s_ready);
        sb.predict_request(kind, address);
    endtask

    // wait until every word has come back and the block sits idle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    task automatic cfg_done();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_config();
        logic [31:0] b;
        logic [16:0] nb;
        case ($urandom_range(0, 3))
            0: b = 32'd0;
            1: b = 32'hFFFF_FFFF - $urandom_range(0, 32'h000F_FFFF);
            2: b = {8'($urandom_range(0, 255)), 24'h0};
            default: b = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: nb = 17'd1 << $urandom_range(0, 16);
            1: nb = 17'($urandom_range(1, 64));
            2: nb = 17'($urandom_range(1, 131071));
            3: nb = 17'd0;
            default: nb = 17'd131071;
        endcase
        cfg_write(REG_POOL_BASE, b);
        cfg_write(REG_BLOCK_BYTES, 32'(nb));
        // sometimes keep the current stack contents across the change
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0: cfg_write(REG_BLOCK_COUNT, 32'd1);
                1: cfg_write(REG_BLOCK_COUNT, 32'd2);
                2: cfg_write(REG_BLOCK_COUNT, $urandom_range(3, 16));
                3: cfg_write(REG_BLOCK_COUNT, $urandom_range(1, 256));
                4: cfg_write(REG_BLOCK_COUNT, 32'd256);
                default: cfg_write(REG_BLOCK_COUNT, $urandom_range(257, 511));
            endcase
        end
        cfg_done();
    endtask

    // mostly blocks handed out earlier, plus null, misaligned and stray addresses
    function automatic logic [31:0] pick_free_address();
        int          r;
        int          i;
        logic [16:0] eb;
        logic [8:0]  cnt;
        logic [31:0] a;
        eb  = sb.eff_bytes();
        cnt = sb.eff_count();
        r   = $urandom_range(0, 99);
        if (r < 55 && sb.live.size() > 0) begin
            i = $urandom_range(0, sb.live.size() - 1);
            a = sb.live[i];
            // leave some in the list so they come back as double frees
            if ($urandom_range(0, 9) != 0) sb.live.delete(i);
        end else if (r < 62) begin
            a = 32'd0;
        end else if (r < 72) begin
            a = sb.base + 32'(eb) * $urandom_range(0, 255) + $urandom_range(1, 32'(eb));
        end else if (r < 76) begin
            a = sb.base + 32'(eb) * 32'(cnt) + $urandom_range(0, 3 * 32'(eb));
        end else if (r < 80) begin
            a = sb.base - 32'd1 - $urandom_range(0, 32'(eb));
        end else if (r < 92) begin
            a = sb.base + 32'(eb) * $urandom_range(0, (cnt == 9'd0) ? 0 : 32'(cnt) - 1);
        end else begin
            a = $urandom;
        end
        return a;
    endfunction

    // result side: random stalls, one long hold when asked
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end else begin
                stall = $urandom_range(0, recv_gap_max);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int phase;
        int n;
        int alloc_pct;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset pool: base 0, 64 byte blocks, all 256 free
        run_request(REQ_FREE, 32'd0);
        run_request(REQ_FREE, 32'd64);
        run_request(REQ_ALLOC, 32'hFFFF_FFFF);
        run_request(REQ_FREE, 32'd16320);
        run_request(REQ_FREE, 32'd16320);
        run_request(REQ_FREE, 32'd16321);
        run_request(REQ_FREE, 32'd16384);
        run_request(REQ_FREE, 32'hFFFF_FFFF);

        // empty pool
        drain();
        cfg_write(REG_BLOCK_COUNT, 32'd0);
        cfg_done();
        run_request(REQ_ALLOC, 32'd0);
        run_request(REQ_FREE, 32'd64);

        // pool that wraps past the top of the address space onto address zero
        drain();
        cfg_write(REG_POOL_BASE, 32'hFFFF_FFC0);
        cfg_write(REG_BLOCK_COUNT, 32'd4);
        cfg_done();
        repeat (5) run_request(REQ_ALLOC, 32'd0);
        run_request(REQ_FREE, 32'd0);
        run_request(REQ_FREE, 32'h0000_0040);
        run_request(REQ_FREE, 32'hFFFF_FFC1);
        run_request(REQ_FREE, 32'h0000_00C0);

        // moving the base leaves the stack alone
        drain();
        cfg_write(REG_POOL_BASE, 32'h0000_1000);
        cfg_done();
        run_request(REQ_ALLOC, 32'd0);

        // zero block size acts as one byte, oversized count clamps to the stack depth
        drain();
        cfg_write(REG_BLOCK_BYTES, 32'd0);
        cfg_write(REG_BLOCK_COUNT, 32'd511);
        cfg_done();
        run_request(REQ_ALLOC, 32'd0);
        run_request(REQ_FREE, 32'h0000_10FF);
        run_request(REQ_FREE, 32'h0000_1100);

        drain();
        cfg_write(REG_POOL_BASE, 32'hFFFF_FFFF);
        cfg_write(REG_BLOCK_BYTES, 32'd131071);
        cfg_write(REG_BLOCK_COUNT, 32'd256);
        cfg_done();
        run_request(REQ_ALLOC, 32'd0);
        run_request(REQ_FREE, 32'hFFFF_FFFF + 32'd255 * 32'd131071);

        for (phase = 0; phase < 10; phase++) begin
            drain();
            send_gap_max = (phase % 3 == 1) ? 0 : 18;
            recv_gap_max = send_gap_max;
            case (phase)
                0: begin
                    cfg_write(REG_POOL_BASE, 32'd0);
                    cfg_write(REG_BLOCK_BYTES, 32'd1);
                    cfg_write(REG_BLOCK_COUNT, 32'd1);
                    cfg_done();
                end
                1: begin
                    cfg_write(REG_POOL_BASE, 32'hFFFF_0000);
                    cfg_write(REG_BLOCK_BYTES, 32'd131071);
                    cfg_write(REG_BLOCK_COUNT, 32'd256);
                    cfg_done();
                end
                2: begin
                    cfg_write(REG_POOL_BASE, $urandom);
                    cfg_write(REG_BLOCK_BYTES, 32'd65536);
                    cfg_write(REG_BLOCK_COUNT, 32'd2);
                    cfg_done();
                end
                3: begin
                    cfg_write(REG_POOL_BASE, 32'hFFFF_FFFF);
                    cfg_write(REG_BLOCK_BYTES, 32'd1);
                    cfg_write(REG_BLOCK_COUNT, 32'd511);
                    cfg_done();
                end
                default: random_config();
            endcase
            alloc_pct = $urandom_range(30, 70);
            for (n = 0; n < 183; n++) begin
                // block the result side so the input backs up behind it
                if (phase == 2 && n == 20) hold_off = 400;
                if (phase == 5 && n == 90) drain();
                if ($urandom_range(0, 99) < alloc_pct) begin
                    run_request(REQ_ALLOC, $urandom);
                end else begin
                    run_request(REQ_FREE, pick_free_address());
                end
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fbfs_pkg.sv
hw/rtl/fbfs_stack.sv
hw/rtl/fbfs_divider.sv
hw/rtl/fixed_block_free_stack_allocator.sv
hw/rtl/fbfs_checker.sv
tb/fixed_block_free_stack_allocator_test.sv
